// ----- design/i2cra_pkg.sv -----
`timescale 1ns / 1ps

package i2cra_pkg;

    // Bus operations that a transaction script is built from.
    typedef enum logic [3:0] {
        OP_END   = 4'd0,
        OP_START = 4'd1,
        OP_STOP  = 4'd2,
        OP_NACK  = 4'd3,
        OP_RD    = 4'd4,
        OP_WDEVW = 4'd5,
        OP_WDEVR = 4'd6,
        OP_WAH   = 4'd7,
        OP_WAL   = 4'd8,
        OP_WDH   = 4'd9,
        OP_WDL   = 4'd10
    } t_op;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DEVICE_ADDR = 1'b0,
        CFG_DELAY_TICKS = 1'b1
    } t_cfg_idx;

    localparam int unsigned SCRIPT_LEN  = 25;
    localparam int unsigned PHASE_W     = $clog2(SCRIPT_LEN);
    localparam logic [PHASE_W-1:0] WRITE_ENTRY = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] READ_ENTRY  = PHASE_W'(9);

    localparam logic [6:0]  DEVICE_ADDR_RST = 7'h10;
    localparam logic [15:0] DELAY_TICKS_RST = 16'd100;

    // Pin vector: bit 0 SCL, bit 1 SDA, bit 2 SDA output enable.
    typedef logic [2:0] t_pins;
    localparam t_pins PINS_RST = 3'b011;

    // Transaction script. Phase 0 is idle; the write script starts at phase 1 and
    // the read script at phase 9.
    function automatic t_op f_script(input logic [PHASE_W-1:0] phase);
        t_op op;
        case (phase)
            5'd1, 5'd9, 5'd14, 5'd19:  op = OP_START;
            5'd2, 5'd10:               op = OP_WDEVW;
            5'd3, 5'd11:               op = OP_WAH;
            5'd4, 5'd12:               op = OP_WAL;
            5'd5:                      op = OP_WDH;
            5'd6:                      op = OP_WDL;
            5'd7, 5'd13, 5'd18, 5'd23: op = OP_STOP;
            5'd15, 5'd20:              op = OP_WDEVR;
            5'd16, 5'd21:              op = OP_RD;
            5'd17, 5'd22:              op = OP_NACK;
            default:                   op = OP_END;
        endcase
        return op;
    endfunction

endpackage

// ----- design/i2c_register_access_master_top.sv -----
`timescale 1ns / 1ps

// Channel      Dir  Fields (lowest bit first)
// s_axis       in   tdata: start_req, reg_addr, wr_data, sda_line; tuser: req_type
// m_axis       out  tdata: scl_out, sda_out, sda_oe, busy_res, done_res, rd_data, ack_error
// cfg          in   i_cfg_idx 0: device_addr, 1: delay_ticks (write only)
//
// Every item is one bus tick and yields one registered result item in the cycle after it is taken.
// A new item is taken every cycle while the result register is empty or being drained;
// the rate is set by the single combinational tick update between the state registers
// and the result register. Reset (synchronous, active low) returns the bus state to idle
// with SCL high and SDA released, and the configuration to address 0x10, 100 ticks.
// A stalled output holds its result and blocks further input until it is taken.

module i2c_register_access_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // start_req, reg_addr[15:0], wr_data[15:0], sda_line
    input  logic        s_axis_tuser,  // req_type
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // scl_out, sda_out, sda_oe, busy_res, done_res,
                                       // rd_data[15:0], ack_error
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import i2cra_pkg::*;

    // Configuration registers.
    logic [6:0]  r_device_addr;
    logic [15:0] r_delay_ticks;

    // Bus state.
    logic [PHASE_W-1:0] r_phase,       n_phase;
    logic [3:0]         r_bit_count,   n_bit_count;
    logic               r_byte_odd,    n_byte_odd;
    logic [7:0]         r_shift_byte,  n_shift_byte;
    logic [15:0]        r_delay_count, n_delay_count;
    logic [15:0]        r_latched_addr, n_latched_addr;
    logic [15:0]        r_latched_data, n_latched_data;
    logic [15:0]        r_read_result, n_read_result;
    logic               r_error_flag,  n_error_flag;
    t_pins              r_pins,        n_pins;

    // Result register.
    logic        r_out_valid;
    logic [21:0] r_out_data, n_out_data;

    logic        w_accept;
    logic [15:0] w_delay_eff;

    // Input field views.
    logic        w_start_req;
    logic        w_req_type;
    logic [15:0] w_reg_addr;
    logic [15:0] w_wr_data;
    logic        w_sda_line;

    assign w_start_req = s_axis_tdata[0];
    assign w_reg_addr  = s_axis_tdata[16:1];
    assign w_wr_data   = s_axis_tdata[32:17];
    assign w_sda_line  = s_axis_tdata[33];
    assign w_req_type  = s_axis_tuser;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

    // A segment length of zero behaves as one tick.
    assign w_delay_eff = (r_delay_ticks == 16'd0) ? 16'd1 : r_delay_ticks;

    // Byte that an operation shifts out when it begins; control operations keep
    // whatever is in the shift register.
    function automatic logic [7:0] f_load(input t_op op, input logic [6:0] dev,
                                          input logic [15:0] addr, input logic [15:0] data,
                                          input logic [7:0] cur);
        logic [7:0] b;
        case (op)
            OP_WDEVW: b = {dev, 1'b0};
            OP_WDEVR: b = {dev, 1'b1};
            OP_WAH:   b = addr[15:8];
            OP_WAL:   b = addr[7:0];
            OP_WDH:   b = data[15:8];
            OP_WDL:   b = data[7:0];
            OP_RD:    b = 8'h00;
            default:  b = cur;
        endcase
        return b;
    endfunction

    // Pin levels of the segment selected by operation, step and clock half.
    function automatic t_pins f_pins(input t_op op, input logic [3:0] bc, input logic half,
                                     input logic [7:0] sb);
        t_pins p;
        case (op)
            OP_START: p = (bc == 4'd0) ? 3'b111 : 3'b101;
            OP_STOP: begin
                if (bc == 4'd0)      p = 3'b100;
                else if (bc == 4'd1) p = 3'b101;
                else                 p = 3'b111;
            end
            OP_NACK: begin
                if (bc == 4'd0)      p = 3'b110;
                else if (bc == 4'd1) p = 3'b111;
                else if (bc == 4'd2) p = 3'b110;
                else                 p = 3'b100;
            end
            OP_RD: p = {2'b01, half};
            default: begin
                if (bc < 4'd8) p = {1'b1, sb[~bc[2:0]], half};
                else           p = {2'b01, half};
            end
        endcase
        return p;
    endfunction

    // One bus tick: optional start of a transaction, then the segment countdown and,
    // on the last tick of a segment, the step to the next segment or operation.
    always_comb begin
        t_op    v_op;
        t_pins  v_out_pins;
        logic   v_busy;
        logic   v_done;
        logic   v_next;
        logic [3:0] v_limit;

        n_phase        = r_phase;
        n_bit_count    = r_bit_count;
        n_byte_odd     = r_byte_odd;
        n_shift_byte   = r_shift_byte;
        n_delay_count  = r_delay_count;
        n_latched_addr = r_latched_addr;
        n_latched_data = r_latched_data;
        n_read_result  = r_read_result;
        n_error_flag   = r_error_flag;
        n_pins         = r_pins;
        v_op           = OP_END;
        v_busy         = 1'b0;
        v_done         = 1'b0;
        v_next         = 1'b0;
        v_limit        = 4'd4;

        if (r_phase == '0 && w_start_req) begin
            n_latched_addr = w_reg_addr;
            n_latched_data = w_wr_data;
            n_error_flag   = 1'b0;
            n_byte_odd     = 1'b0;
            n_phase        = w_req_type ? READ_ENTRY : WRITE_ENTRY;
            n_bit_count    = 4'd0;
            v_op           = f_script(n_phase);
            n_shift_byte   = f_load(v_op, r_device_addr, w_reg_addr, w_wr_data,
                                    r_shift_byte);
            n_pins         = f_pins(v_op, 4'd0, 1'b0, n_shift_byte);
            n_delay_count  = w_delay_eff;
        end

        // The result shows the pins as they stand at the start of this tick.
        v_out_pins = n_pins;

        if (n_phase != '0) begin
            v_busy = 1'b1;
            if (n_delay_count > 16'd1) begin
                n_delay_count = n_delay_count - 16'd1;
            end else begin
                v_op = f_script(n_phase);
                if (v_op == OP_RD || v_op >= OP_WDEVW) begin
                    if (!n_pins[0]) begin
                        // Low half done: raise SCL on the same bit.
                        n_pins        = f_pins(v_op, n_bit_count, 1'b1, n_shift_byte);
                        n_delay_count = w_delay_eff;
                    end else if (v_op == OP_RD) begin
                        n_shift_byte = {n_shift_byte[6:0], w_sda_line};
                        if (n_bit_count >= 4'd7) begin
                            if (!n_byte_odd) n_read_result[15:8] = n_shift_byte;
                            else             n_read_result[7:0]  = n_shift_byte;
                            n_byte_odd = !n_byte_odd;
                            v_next     = 1'b1;
                        end else begin
                            n_bit_count   = n_bit_count + 4'd1;
                            n_pins        = f_pins(v_op, n_bit_count, 1'b0, n_shift_byte);
                            n_delay_count = w_delay_eff;
                        end
                    end else if (n_bit_count >= 4'd8) begin
                        // Acknowledge slot of a written byte.
                        n_error_flag = n_error_flag | w_sda_line;
                        v_next       = 1'b1;
                    end else begin
                        n_bit_count   = n_bit_count + 4'd1;
                        n_pins        = f_pins(v_op, n_bit_count, 1'b0, n_shift_byte);
                        n_delay_count = w_delay_eff;
                    end
                end else begin
                    if (v_op == OP_START)     v_limit = 4'd2;
                    else if (v_op == OP_STOP) v_limit = 4'd3;
                    else                      v_limit = 4'd4;
                    n_bit_count = n_bit_count + 4'd1;
                    if (n_bit_count < v_limit) begin
                        n_pins        = f_pins(v_op, n_bit_count, 1'b0, n_shift_byte);
                        n_delay_count = w_delay_eff;
                    end else begin
                        v_next = 1'b1;
                    end
                end

                if (v_next) begin
                    n_phase     = n_phase + PHASE_W'(1);
                    n_bit_count = 4'd0;
                    v_op        = f_script(n_phase);
                    if (v_op == OP_END) begin
                        // End of script: back to idle, pins keep their levels.
                        n_phase = '0;
                        v_done  = 1'b1;
                    end else begin
                        n_shift_byte  = f_load(v_op, r_device_addr, n_latched_addr,
                                               n_latched_data, n_shift_byte);
                        n_pins        = f_pins(v_op, 4'd0, 1'b0, n_shift_byte);
                        n_delay_count = w_delay_eff;
                    end
                end
            end
        end

        n_out_data = {n_error_flag, n_read_result, v_done, v_busy, v_out_pins[2],
                      (v_out_pins[2] ? v_out_pins[1] : 1'b1), v_out_pins[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_addr <= DEVICE_ADDR_RST;
            r_delay_ticks <= DELAY_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEVICE_ADDR: r_device_addr <= i_cfg_data[6:0];
                CFG_DELAY_TICKS: r_delay_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_bit_count   <= 4'd0;
            r_byte_odd    <= 1'b0;
            r_shift_byte  <= 8'h00;
            r_delay_count <= 16'd0;
            r_read_result <= 16'd0;
            r_error_flag  <= 1'b0;
            r_pins        <= PINS_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase       <= n_phase;
                r_bit_count   <= n_bit_count;
                r_byte_odd    <= n_byte_odd;
                r_shift_byte  <= n_shift_byte;
                r_delay_count <= n_delay_count;
                r_read_result <= n_read_result;
                r_error_flag  <= n_error_flag;
                r_pins        <= n_pins;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_latched_addr <= n_latched_addr;
            r_latched_data <= n_latched_data;
            r_out_data     <= n_out_data;
        end
    end

endmodule
